// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file wvma_chk.sv.
// Both macros expect signals clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WVMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WVMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/wvma_pkg.sv -----
// Package for the wind vector moving average block.
// Holds widths, action codes, CORDIC angle table and shared types; no dependencies.
`default_nettype none

package wvma_pkg;

  localparam int MAX_INTERVALS  = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int CORDIC_STEPS   = 20;

  localparam int DW      = 56;
  localparam int ZW      = 32;
  localparam int SUM_W   = 48;
  localparam int SAMP_W  = 16;
  localparam int WCNT_W  = 20;
  localparam int DIR_W   = 9;
  localparam int SPD_W   = 16;
  localparam int CFG_W   = 5;
  localparam int IDX_W   = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_W   = $clog2(MAX_INTERVALS + 1);
  localparam int ITER_W  = $clog2(CORDIC_STEPS);
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam int DEN_W   = WCNT_W + TRIG_FRAC_BITS;
  localparam int RAM_W   = 2 * SUM_W + SAMP_W;
  localparam int GAIN_W  = 30;

  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [CFG_W-1:0]  CFG_RESET    = 5'd16;

  localparam logic signed [ZW-1:0] DEG90_Q16  = 32'sd5898240;
  localparam logic signed [ZW-1:0] DEG360_Q16 = 32'sd23592960;
  localparam logic signed [ZW-1:0] HALF_DEG   = 32'sd32768;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_CLOSE  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [ZW-1:0] ang_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_ctrl_t;

  function automatic ang_t atan_q16(input logic [ITER_W-1:0] i);
    ang_t a;
    case (i)
      5'd0:    a = 32'sd2949120;
      5'd1:    a = 32'sd1740967;
      5'd2:    a = 32'sd919879;
      5'd3:    a = 32'sd466945;
      5'd4:    a = 32'sd234379;
      5'd5:    a = 32'sd117304;
      5'd6:    a = 32'sd58666;
      5'd7:    a = 32'sd29335;
      5'd8:    a = 32'sd14668;
      5'd9:    a = 32'sd7334;
      5'd10:   a = 32'sd3667;
      5'd11:   a = 32'sd1833;
      5'd12:   a = 32'sd917;
      5'd13:   a = 32'sd458;
      5'd14:   a = 32'sd229;
      5'd15:   a = 32'sd115;
      5'd16:   a = 32'sd57;
      5'd17:   a = 32'sd29;
      5'd18:   a = 32'sd14;
      5'd19:   a = 32'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/wvma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wvma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/wvma_cordic.sv -----
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on wvma_pkg.
`default_nettype none

module wvma_cordic (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire wvma_pkg::cordic_ctrl_t  ctrl,
  input  wire wvma_pkg::data_t         x_in,
  input  wire wvma_pkg::data_t         y_in,
  input  wire wvma_pkg::ang_t          z_in,
  output wvma_pkg::data_t              x,
  output wvma_pkg::data_t              y,
  output wvma_pkg::ang_t               z,
  output logic                         done
);

  import wvma_pkg::*;

  logic              busy;
  logic              rotate;
  logic [ITER_W-1:0] iter;
  data_t             xs;
  data_t             ys;
  ang_t              at;
  logic              dneg;

  always_comb begin
    xs   = x >>> iter;
    ys   = y >>> iter;
    at   = atan_q16(iter);
    dneg = rotate ? !z[ZW-1] : y[DW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        x      <= x_in;
        y      <= y_in;
        z      <= z_in;
        rotate <= ctrl.rotate;
        iter   <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (dneg) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/wvma_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturates at all ones.
// Depends on wvma_pkg.
`default_nettype none

module wvma_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [wvma_pkg::DW-1:0]         num,
  input  wire logic [wvma_pkg::DEN_W-1:0]      den,
  output logic      [wvma_pkg::SPD_W-1:0]      quo,
  output logic                                 done
);

  import wvma_pkg::*;

  localparam int BIT_W = $clog2(SPD_W);

  logic             busy;
  logic [DW-1:0]    rem;
  logic [DEN_W-1:0] dv;
  logic [BIT_W-1:0] bitpos;
  logic [DW-1:0]    trial;
  logic             ovf;

  always_comb begin
    trial = DW'(dv) << bitpos;
    ovf   = (num >> SPD_W) >= DW'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (ovf) begin
          quo  <= '1;
          done <= 1'b1;
        end else begin
          rem    <= num;
          dv     <= den;
          quo    <= '0;
          bitpos <= BIT_W'(SPD_W - 1);
          busy   <= 1'b1;
        end
      end else if (busy) begin
        if (rem >= trial) begin
          rem         <= rem - trial;
          quo[bitpos] <= 1'b1;
        end
        if (bitpos == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bitpos <= bitpos - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/wind_vector_moving_average_top.sv -----
// Wind vector averager: each item takes a sample, closes the interval into the ring,
// clears the interval or does none of these, then reports direction and speed of the
// interval and of the ring window. One shared 20-step CORDIC runs for the sample's cosine
// and sine and again for each of the two vectors, one 16-step divider runs for each speed,
// and the window sum reads the ring memory one entry at a time. An empty vector skips the
// CORDIC and the divider.
// The input is stalled from acceptance until the result item has been taken.
// Depends on wvma_pkg, wvma_cordic, wvma_div and wvma_ram.
`default_nettype none

module wind_vector_moving_average_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [wvma_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   action,
  input  wire logic [15:0]                  speed,
  input  wire logic [8:0]                   direction,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [wvma_pkg::DIR_W-1:0]        interval_direction,
  output logic [wvma_pkg::SPD_W-1:0]        interval_speed,
  output logic [wvma_pkg::SAMP_W-1:0]       interval_count,
  output logic [wvma_pkg::DIR_W-1:0]        window_direction,
  output logic [wvma_pkg::SPD_W-1:0]        window_speed,
  output logic [wvma_pkg::WCNT_W-1:0]       window_count
);

  import wvma_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ACT, S_TRIG, S_MUL_E, S_MUL_N, S_VA_START, S_VA_CORDIC, S_MAG_HI,
    S_MAG_LO, S_DIV_START, S_DIV_WAIT, S_VA_STORE, S_WIN_INIT, S_WIN_READ,
    S_WIN_ACC, S_OUT
  } state_t;

  state_t state;

  logic [1:0]                act_r;
  logic [15:0]               spd_r;
  logic [8:0]                dir_r;
  logic [CFG_W-1:0]          wi;
  logic signed [SUM_W-1:0]   cur_e;
  logic signed [SUM_W-1:0]   cur_n;
  logic [SAMP_W-1:0]         cur_cnt;
  logic [CNT_W-1:0]          write_slot;
  logic [CNT_W-1:0]          filled;
  logic [1:0]                quad;
  logic signed [TRIG_W-1:0]  trig_c;
  logic signed [TRIG_W-1:0]  trig_s;
  logic                      va_win;
  logic [WCNT_W-1:0]         va_cnt;
  logic [DIR_W-1:0]          va_dir;
  logic [SPD_W-1:0]          va_spd;
  logic [DW-1:0]             va_mag;
  logic [GAIN_W-1:0]         va_lo;
  data_t                     we;
  data_t                     wn;
  logic [WCNT_W-1:0]         wc;
  logic [CNT_W-1:0]          widx;

  cordic_ctrl_t              cc;
  data_t                     cx_in;
  data_t                     cy_in;
  ang_t                      cz_in;
  data_t                     cx;
  data_t                     cy;
  ang_t                      cz;
  logic                      c_done;

  logic                      d_start;
  logic [DW-1:0]             d_num;
  logic [DEN_W-1:0]          d_den;
  logic [SPD_W-1:0]          d_quo;
  logic                      d_done;

  logic                      ram_we;
  logic                      ram_re;
  logic [RAM_W-1:0]          ram_rdata;

  logic [CNT_W-1:0]          len;
  logic [CNT_W-1:0]          slot;
  logic [CNT_W-1:0]          win_n;
  logic [8:0]                dred;
  logic [8:0]                rdeg;
  logic [1:0]                qdeg;
  logic signed [TRIG_W-1:0]  rc;
  logic signed [TRIG_W-1:0]  rs;
  logic signed [TRIG_W+16:0] prod_e;
  logic signed [TRIG_W+16:0] prod_n;
  data_t                     src_u;
  data_t                     src_v;
  logic [WCNT_W-1:0]         src_cnt;
  ang_t                      zf;
  logic [ZW-1:0]             dgw;
  logic [9:0]                dg;
  logic [DEN_W-1:0]          den;
  logic [DW-1:0]             mag_hi;
  logic [2*GAIN_W-1:0]       mag_lo;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    if (wi == '0) begin
      len = CNT_W'(1);
    end else if (int'(wi) > MAX_INTERVALS) begin
      len = CNT_W'(MAX_INTERVALS);
    end else begin
      len = CNT_W'(wi);
    end
    slot  = (write_slot >= len) ? '0 : write_slot;
    win_n = (filled < len) ? filled : len;

    dred = (dir_r >= 9'd360) ? dir_r - 9'd360 : dir_r;
    if (dred < 9'd90) begin
      qdeg = 2'd0;
      rdeg = dred;
    end else if (dred < 9'd180) begin
      qdeg = 2'd1;
      rdeg = dred - 9'd90;
    end else if (dred < 9'd270) begin
      qdeg = 2'd2;
      rdeg = dred - 9'd180;
    end else begin
      qdeg = 2'd3;
      rdeg = dred - 9'd270;
    end

    rc = TRIG_W'((cx + (data_t'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
    rs = TRIG_W'((cy + (data_t'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));

    prod_e = $signed({1'b0, spd_r}) * trig_c;
    prod_n = $signed({1'b0, spd_r}) * trig_s;

    src_u   = va_win ? we : data_t'(cur_e);
    src_v   = va_win ? wn : data_t'(cur_n);
    src_cnt = va_win ? wc : WCNT_W'(cur_cnt);

    zf  = cz[ZW-1] ? cz + DEG360_Q16 : cz;
    dgw = (zf + HALF_DEG) >> 16;
    dg  = (dgw[9:0] >= 10'd360) ? dgw[9:0] - 10'd360 : dgw[9:0];

    den = {va_cnt, {TRIG_FRAC_BITS{1'b0}}};

    mag_hi = va_mag[DW-1:GAIN_W] * INV_GAIN_Q30;
    mag_lo = va_lo * INV_GAIN_Q30;

    ram_we = (state == S_ACT) && (act_r == ACT_CLOSE);
    ram_re = (state == S_WIN_READ);
  end

  wvma_cordic u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cc),
    .x_in (cx_in),
    .y_in (cy_in),
    .z_in (cz_in),
    .x    (cx),
    .y    (cy),
    .z    (cz),
    .done (c_done)
  );

  wvma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (d_start),
    .num   (d_num),
    .den   (d_den),
    .quo   (d_quo),
    .done  (d_done)
  );

  wvma_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_INTERVALS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot[IDX_W-1:0]),
    .wdata ({cur_e, cur_n, cur_cnt}),
    .re    (ram_re),
    .raddr (widx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wi         <= CFG_RESET;
      cur_e      <= '0;
      cur_n      <= '0;
      cur_cnt    <= '0;
      write_slot <= '0;
      filled     <= '0;
      out_valid  <= 1'b0;
      cc         <= '0;
      d_start    <= 1'b0;
      va_win     <= 1'b0;
    end else begin
      cc.start <= 1'b0;
      d_start  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        wi <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_r  <= action;
            spd_r  <= speed;
            dir_r  <= direction;
            va_win <= 1'b0;
            state  <= S_ACT;
          end
        end
        S_ACT: begin
          state <= S_VA_START;
          case (act_r)
            ACT_SAMPLE: begin
              if (cur_cnt != '1) begin
                quad      <= qdeg;
                cx_in     <= data_t'(INV_GAIN_Q30);
                cy_in     <= '0;
                cz_in     <= ang_t'(rdeg) <<< 16;
                cc.start  <= 1'b1;
                cc.rotate <= 1'b1;
                state     <= S_TRIG;
              end
            end
            ACT_CLOSE: begin
              write_slot <= slot + 1'b1;
              filled     <= (filled < len) ? filled + 1'b1 : len;
              cur_e      <= '0;
              cur_n      <= '0;
              cur_cnt    <= '0;
            end
            ACT_CLEAR: begin
              cur_e   <= '0;
              cur_n   <= '0;
              cur_cnt <= '0;
            end
            default: begin
            end
          endcase
        end
        S_TRIG: begin
          if (c_done) begin
            case (quad)
              2'd0: begin
                trig_c <= rc;
                trig_s <= rs;
              end
              2'd1: begin
                trig_c <= -rs;
                trig_s <= rc;
              end
              2'd2: begin
                trig_c <= -rc;
                trig_s <= -rs;
              end
              default: begin
                trig_c <= rs;
                trig_s <= -rc;
              end
            endcase
            state <= S_MUL_E;
          end
        end
        S_MUL_E: begin
          cur_e <= cur_e + SUM_W'(prod_e);
          state <= S_MUL_N;
        end
        S_MUL_N: begin
          cur_n   <= cur_n + SUM_W'(prod_n);
          cur_cnt <= cur_cnt + 1'b1;
          state   <= S_VA_START;
        end
        S_VA_START: begin
          va_cnt <= src_cnt;
          if (src_cnt == '0 || (src_u == '0 && src_v == '0)) begin
            va_dir <= '0;
            va_spd <= '0;
            state  <= S_VA_STORE;
          end else begin
            if (src_u[DW-1]) begin
              if (!src_v[DW-1]) begin
                cx_in <= src_v;
                cy_in <= -src_u;
                cz_in <= DEG90_Q16;
              end else begin
                cx_in <= -src_v;
                cy_in <= src_u;
                cz_in <= -DEG90_Q16;
              end
            end else begin
              cx_in <= src_u;
              cy_in <= src_v;
              cz_in <= '0;
            end
            cc.start  <= 1'b1;
            cc.rotate <= 1'b0;
            state     <= S_VA_CORDIC;
          end
        end
        S_VA_CORDIC: begin
          if (c_done) begin
            va_dir <= DIR_W'(dg);
            va_mag <= cx[DW-1] ? '0 : DW'(cx);
            va_lo  <= cx[DW-1] ? '0 : cx[GAIN_W-1:0];
            state  <= S_MAG_HI;
          end
        end
        S_MAG_HI: begin
          va_mag <= mag_hi;
          state  <= S_MAG_LO;
        end
        S_MAG_LO: begin
          va_mag <= va_mag + DW'(mag_lo[2*GAIN_W-1:GAIN_W]);
          state  <= S_DIV_START;
        end
        S_DIV_START: begin
          d_num   <= va_mag + DW'(den >> 1);
          d_den   <= den;
          d_start <= 1'b1;
          state   <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (d_done) begin
            va_spd <= d_quo;
            state  <= S_VA_STORE;
          end
        end
        S_VA_STORE: begin
          if (!va_win) begin
            interval_direction <= va_dir;
            interval_speed     <= va_spd;
            state              <= S_WIN_INIT;
          end else begin
            window_direction <= va_dir;
            window_speed     <= va_spd;
            interval_count   <= cur_cnt;
            window_count     <= wc;
            out_valid        <= 1'b1;
            state            <= S_OUT;
          end
        end
        S_WIN_INIT: begin
          we   <= '0;
          wn   <= '0;
          wc   <= '0;
          widx <= '0;
          if (win_n == '0) begin
            va_win <= 1'b1;
            state  <= S_VA_START;
          end else begin
            state <= S_WIN_READ;
          end
        end
        S_WIN_READ: begin
          state <= S_WIN_ACC;
        end
        S_WIN_ACC: begin
          we   <= we + data_t'($signed(ram_rdata[RAM_W-1 -: SUM_W]));
          wn   <= wn + data_t'($signed(ram_rdata[SAMP_W +: SUM_W]));
          wc   <= wc + WCNT_W'(ram_rdata[SAMP_W-1:0]);
          widx <= widx + 1'b1;
          if (widx + 1'b1 == win_n) begin
            va_win <= 1'b1;
            state  <= S_VA_START;
          end else begin
            state <= S_WIN_READ;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/wvma_chk.sv -----
// Port-level checker for the wind vector averager, bound to the top level.
// Depends on wvma_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module wvma_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [wvma_pkg::DIR_W-1:0]   interval_direction,
  input wire logic [wvma_pkg::SPD_W-1:0]   interval_speed,
  input wire logic [wvma_pkg::SAMP_W-1:0]  interval_count,
  input wire logic [wvma_pkg::DIR_W-1:0]   window_direction
);

  logic dir_ok;
  logic empty_ok;

  assign dir_ok   = (interval_direction < 9'd360) && (window_direction < 9'd360);
  assign empty_ok = (interval_speed == '0) && (interval_direction == '0);

  `WVMA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result item dropped")
  `WVMA_ASSERT_IMP(a_busy_stall, out_valid, in_stall, "input taken while a result waits")
  `WVMA_ASSERT_NXT(a_no_same_result, in_valid && !in_stall, !out_valid, "result too early")
  `WVMA_ASSERT_IMP(a_dir_range, out_valid, dir_ok, "direction out of range")
  `WVMA_ASSERT_IMP(a_empty_zero, out_valid && interval_count == '0, empty_ok, "empty not zero")

endmodule

bind wind_vector_moving_average_top wvma_chk u_wvma_chk (.*);

`default_nettype wire

// ----- tb/wind_vector_moving_average_top_tb.sv -----
// Testbench for wind_vector_moving_average_top: directed and random items under random
// gaps and stalls, checked item by item against a bit-exact vector averaging predictor.
// Depends on wvma_pkg and the RTL of the block only.
`default_nettype none

module wind_vector_moving_average_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wvma_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct {
    logic [8:0]  int_dir;
    logic [15:0] int_spd;
    logic [15:0] int_cnt;
    logic [8:0]  win_dir;
    logic [15:0] win_spd;
    logic [19:0] win_cnt;
  } wind_result_t;

  class wind_average_board;
    longint cur_east, cur_north;
    int unsigned cur_cnt;
    longint ring_east[MAX_INTERVALS], ring_north[MAX_INTERVALS];
    int unsigned ring_cnt[MAX_INTERVALS];
    bit ring_written[MAX_INTERVALS];
    int unsigned slot, filled, win_reg;
    wind_result_t awaited[$];
    int errors;

    function new();
      cur_east = 0; cur_north = 0; cur_cnt = 0;
      slot = 0; filled = 0; win_reg = 16; errors = 0;
      foreach (ring_written[i]) ring_written[i] = 0;
    endfunction

    function int unsigned win_len();
      if (win_reg < 1) return 1;
      if (win_reg > MAX_INTERVALS) return MAX_INTERVALS;
      return win_reg;
    endfunction

    function void set_window(int unsigned v);
      win_reg = v & 5'h1F;
    endfunction

    // a close must not pull a never-written ring entry into the window
    function bit close_safe();
      int unsigned len, s, nf;
      len = win_len();
      s = (slot >= len) ? 0 : slot;
      nf = (filled < len) ? filled + 1 : len;
      for (int i = 0; i < nf; i++)
        if (!ring_written[i] && i != s) return 0;
      return 1;
    endfunction

    function void heading_trig(int unsigned deg, output longint c, output longint s);
      int unsigned d, q, r;
      longint x, y, z, nx, ny, rc, rs;
      d = deg % 360; q = d / 90; r = d % 90;
      x = INV_GAIN_Q30; y = 0; z = longint'(r) << 16;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(atan_q16(ITER_W'(i)));
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(atan_q16(ITER_W'(i)));
        end
        x = nx; y = ny;
      end
      rc = (x + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      rs = (y + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      case (q)
        0: begin c = rc; s = rs; end
        1: begin c = -rs; s = rc; end
        2: begin c = -rc; s = -rs; end
        default: begin c = rs; s = -rc; end
      endcase
    endfunction

    function void polar_average(longint u, longint v, longint unsigned cnt,
                                output logic [8:0] dir, output logic [15:0] spd);
      longint z, t, nu, nv;
      longint unsigned ux, mag, den, sp, dg;
      dir = 0; spd = 0;
      if (cnt == 0 || (u == 0 && v == 0)) return;
      z = 0;
      if (u < 0) begin
        if (v >= 0) begin t = u; u = v; v = -t; z = longint'(90) << 16; end
        else begin t = u; u = -v; v = t; z = -(longint'(90) << 16); end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (v >= 0) begin
          nu = u + (v >>> i); nv = v - (u >>> i); z += longint'(atan_q16(ITER_W'(i)));
        end else begin
          nu = u - (v >>> i); nv = v + (u >>> i); z -= longint'(atan_q16(ITER_W'(i)));
        end
        u = nu; v = nv;
      end
      if (z < 0) z += longint'(360) << 16;
      dg = (longint'(z) + 32768) >> 16;
      if (dg >= 360) dg -= 360;
      dir = dg[8:0];
      ux = (u < 0) ? 0 : u;
      mag = (ux >> 30) * INV_GAIN_Q30 + (((ux & 64'h3FFF_FFFF) * INV_GAIN_Q30) >> 30);
      den = cnt << TRIG_FRAC_BITS;
      sp = (mag + (den >> 1)) / den;
      spd = (sp > 65535) ? 16'hFFFF : sp[15:0];
    endfunction

    function void note_input(logic [1:0] act, logic [15:0] spd, logic [8:0] dir);
      longint c, s, we, wn;
      longint unsigned wc;
      int unsigned len, n;
      wind_result_t r;
      len = win_len();
      if (act == ACT_SAMPLE) begin
        if (cur_cnt < 65535) begin
          heading_trig(dir, c, s);
          cur_east += longint'(spd) * c;
          cur_north += longint'(spd) * s;
          cur_cnt++;
        end
      end else if (act == ACT_CLOSE) begin
        if (slot >= len) slot = 0;
        ring_east[slot] = cur_east; ring_north[slot] = cur_north;
        ring_cnt[slot] = cur_cnt; ring_written[slot] = 1;
        slot++;
        filled = (filled < len) ? filled + 1 : len;
        cur_east = 0; cur_north = 0; cur_cnt = 0;
      end else if (act == ACT_CLEAR) begin
        cur_east = 0; cur_north = 0; cur_cnt = 0;
      end
      polar_average(cur_east, cur_north, cur_cnt, r.int_dir, r.int_spd);
      r.int_cnt = cur_cnt[15:0];
      n = (filled < len) ? filled : len;
      we = 0; wn = 0; wc = 0;
      for (int i = 0; i < n; i++) begin
        we += ring_east[i]; wn += ring_north[i]; wc += ring_cnt[i];
      end
      polar_average(we, wn, wc, r.win_dir, r.win_spd);
      r.win_cnt = wc[19:0];
      awaited.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(wind_result_t got);
      wind_result_t w;
      if (awaited.size() == 0) begin
        report("result items with nothing awaited", 1, 0);
        return;
      end
      w = awaited.pop_front();
      if (got.int_dir !== w.int_dir) report("interval_direction", got.int_dir, w.int_dir);
      if (got.int_spd !== w.int_spd) report("interval_speed", got.int_spd, w.int_spd);
      if (got.int_cnt !== w.int_cnt) report("interval_count", got.int_cnt, w.int_cnt);
      if (got.win_dir !== w.win_dir) report("window_direction", got.win_dir, w.win_dir);
      if (got.win_spd !== w.win_spd) report("window_speed", got.win_spd, w.win_spd);
      if (got.win_cnt !== w.win_cnt) report("window_count", got.win_cnt, w.win_cnt);
    endtask
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] action;
  logic [15:0] speed;
  logic [8:0] direction;
  logic out_valid, out_stall;
  logic [DIR_W-1:0] interval_direction, window_direction;
  logic [SPD_W-1:0] interval_speed, window_speed;
  logic [SAMP_W-1:0] interval_count;
  logic [WCNT_W-1:0] window_count;

  wind_average_board board = new();
  bit calm, hold_go;
  int stall_left, hold_left, cycles;

  wind_vector_moving_average_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .speed(speed), .direction(direction),
    .out_valid(out_valid), .out_stall(out_stall),
    .interval_direction(interval_direction), .interval_speed(interval_speed),
    .interval_count(interval_count), .window_direction(window_direction),
    .window_speed(window_speed), .window_count(window_count)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    int g;
    if (!rst && out_valid && !out_stall)
      board.check_result('{interval_direction, interval_speed, interval_count,
                           window_direction, window_speed, window_count});
    if (hold_go) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      g = pick_gap();
      out_stall <= (g != 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  task automatic send_item(logic [1:0] act, logic [15:0] spd, logic [8:0] dir);
    int g;
    action <= act;
    speed <= spd;
    direction <= dir;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(act, spd, dir);
    g = calm ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_window(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [1:0] act;
    logic [15:0] spd;
    r = $urandom_range(0, 99);
    if (r < 72) act = ACT_SAMPLE;
    else if (r < 88) act = board.close_safe() ? ACT_CLOSE : ACT_CLEAR;
    else if (r < 96) act = ACT_CLEAR;
    else act = ACT_NONE;
    spd = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    send_item(act, spd, 9'($urandom_range(0, 359)));
  endtask

  initial begin
    int wins[9];
    wins = '{1, 0, 31, 4, 16, 7, 2, 16, 11};
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= ACT_SAMPLE;
    speed <= '0;
    direction <= '0;
    out_stall <= 1'b0;
    calm = 0; hold_go <= 1'b0;
    stall_left <= 0; hold_left <= 0; cycles <= 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_window(5'd16);
    send_item(ACT_CLOSE, 16'd0, 9'd0);
    send_item(ACT_SAMPLE, 16'd0, 9'd0);
    send_item(ACT_SAMPLE, 16'hFFFF, 9'd359);
    send_item(ACT_SAMPLE, 16'hFFFF, 9'd0);
    send_item(ACT_SAMPLE, 16'd1, 9'd1);
    send_item(ACT_NONE, 16'hFFFF, 9'd256);
    send_item(ACT_CLOSE, 16'd0, 9'd0);
    send_item(ACT_SAMPLE, 16'd500, 9'd90);
    send_item(ACT_SAMPLE, 16'd500, 9'd270);
    send_item(ACT_CLOSE, 16'd0, 9'd0);
    send_item(ACT_SAMPLE, 16'd1000, 9'd180);
    send_item(ACT_SAMPLE, 16'd1000, 9'd0);
    send_item(ACT_SAMPLE, 16'd777, 9'd45);
    send_item(ACT_CLEAR, 16'd0, 9'd0);
    send_item(ACT_SAMPLE, 16'hFFFF, 9'd180);
    send_item(ACT_SAMPLE, 16'hFFFF, 9'd270);
    send_item(ACT_SAMPLE, 16'd3, 9'd359);
    send_item(ACT_SAMPLE, 16'd40000, 9'd135);
    send_item(ACT_CLOSE, 16'hFFFF, 9'd359);
    send_item(ACT_CLEAR, 16'd0, 9'd0);
    drain();

    for (int p = 0; p < 9; p++) begin
      write_window(5'(wins[p]));
      calm = (p == 3 || p == 6);
      for (int k = 0; k < 120; k++) begin
        if (p == 2 && k == 10) begin
          hold_go <= 1'b1;
          @(posedge clk);
          hold_go <= 1'b0;
        end
        send_random();
      end
      drain();
    end

    if (board.errors == 0 && board.awaited.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire
